// ===== hdl/smm_pkg.sv =====
// Shared types and codes for the square matrix multiplier.
// No dependencies; imported by square_matrix_multiply and the testbench.
package smm_pkg;

    // Operation carried in the input tuser field
    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    // Register map (byte address bit 2 selects the word)
    localparam logic REG_ROWS_IN_USE = 1'b0;

    localparam logic [2:0] ROWS_RESET = 3'd4;

endpackage

// ===== hdl/square_matrix_multiply.sv =====
// Square matrix multiplier C = A x B with one shared multiply-accumulate.
// Each compute item yields rows * DIM products; each product takes DIM store reads through
// the single MAC (registered read, multiply, accumulate) and waits for a free output register.
// The input is not ready while a compute item is in progress.
// Reset (synchronous, active low) clears the sequencer, output valid and rows_in_use (4);
// the A and B stores are not cleared and hold garbage until written.
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int DIM = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index[1:0], col_index[3:2], element_value[19:4]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[1:0], out_col[3:2], product_value[37:4]
    output logic        m_axis_tlast,   // last_of_run
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = $clog2(DIM * DIM);
    localparam int DEPTH = DIM * DIM;

    // Stores and pipeline
    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];
    logic signed [15:0] r_a_q;
    logic signed [15:0] r_b_q;
    logic signed [31:0] r_prod;
    logic signed [33:0] r_acc;
    logic               r_rd_vld;
    logic               r_mul_vld;

    // Sequencer
    t_state          r_state;
    t_state          n_state;
    logic [IW-1:0]   r_row;
    logic [IW-1:0]   r_col;
    logic [IW-1:0]   r_j;
    logic [2:0]      r_rows_in_use;

    // Output register
    logic               r_out_vld;
    logic [1:0]         r_out_row;
    logic [1:0]         r_out_col;
    logic signed [33:0] r_out_val;
    logic               r_out_last;

    // Decoded input
    t_op         in_op;
    logic [1:0]  in_row;
    logic [1:0]  in_col;
    logic [15:0] in_val;
    logic        in_accept;
    logic        idx_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // Control
    logic       issue;
    logic       pipe_empty;
    logic       out_free;
    logic       out_load;
    logic       j_last;
    logic       col_last;
    logic       elem_last;
    logic       start_ok;
    logic [3:0] rows_lim;
    logic [3:0] row_ext;
    logic [3:0] col_ext;
    logic       cfg_wr;

    assign in_op  = t_op'(s_axis_tuser);
    assign in_row = s_axis_tdata[1:0];
    assign in_col = s_axis_tdata[3:2];
    assign in_val = s_axis_tdata[19:4];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign idx_ok    = (4'(in_row) < 4'(DIM)) && (4'(in_col) < 4'(DIM));
    assign wr_addr   = AW'(in_row) * AW'(DIM) + AW'(in_col);
    assign rd_addr_a = AW'(r_row) * AW'(DIM) + AW'(r_j);
    assign rd_addr_b = AW'(r_j) * AW'(DIM) + AW'(r_col);

    // Clamp the row count to the matrix size
    assign rows_lim = (4'(r_rows_in_use) > 4'(DIM)) ? 4'(DIM) : 4'(r_rows_in_use);
    assign row_ext  = 4'(r_row);
    assign col_ext  = 4'(r_col);
    assign start_ok = (rows_lim != 4'd0);

    assign j_last    = (r_j == IW'(DIM - 1));
    assign col_last  = (r_col == IW'(DIM - 1));
    assign elem_last = col_last && (row_ext == rows_lim - 4'd1);

    assign pipe_empty = !r_rd_vld && !r_mul_vld;
    assign out_free   = !r_out_vld || m_axis_tready;

    // Output decode of the sequencer
    always_comb begin
        issue         = 1'b0;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_RUN:   issue = 1'b1;
            ST_DRAIN: out_load = pipe_empty && out_free;
            default:  ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && in_op == OP_COMPUTE && start_ok) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (j_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    n_state = elem_last ? ST_IDLE : ST_RUN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_mul_vld <= r_rd_vld;
        end
    end

    // Write the stores on load transactions
    always_ff @(posedge i_clk) begin
        if (in_accept && idx_ok && in_op == OP_LOAD_A) begin
            mem_a[wr_addr] <= in_val;
        end
        if (in_accept && idx_ok && in_op == OP_LOAD_B) begin
            mem_b[wr_addr] <= in_val;
        end
    end

    // Registered store reads
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_q <= mem_a[rd_addr_a];
            r_b_q <= mem_b[rd_addr_b];
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if ((r_state == ST_IDLE) || out_load) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + 34'(r_prod);
        end
    end

    // Advance the element counters
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_row <= '0;
            r_col <= '0;
            r_j   <= '0;
        end else begin
            if (issue) begin
                r_j <= j_last ? '0 : r_j + IW'(1);
            end
            if (out_load) begin
                r_col <= col_last ? '0 : r_col + IW'(1);
                if (col_last) begin
                    r_row <= r_row + IW'(1);
                end
            end
        end
    end

    // Output register, refilled as the consumer drains it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row  <= row_ext[1:0];
            r_out_col  <= col_ext[1:0];
            r_out_val  <= r_acc;
            r_out_last <= elem_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_val, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
        end else if (cfg_wr && paddr[2] == REG_ROWS_IN_USE) begin
            r_rows_in_use <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? 32'(r_rows_in_use) : 32'd0;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for square_matrix_multiply: element loads and compute
// transactions on the input stream, predicted products checked on the output stream.
// Depends on smm_pkg and the square_matrix_multiply RTL only.
module tb;
    import smm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM          = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS  = 11;

    typedef struct packed {
        t_op                op;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [15:0] value;
    } t_elem_item;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [33:0] sum;
        logic               last;
    } t_c_entry;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // row_index[1:0], col_index[3:2], element_value[19:4]
    logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // out_row[1:0], out_col[3:2], product_value[37:4]
    logic        m_axis_tlast;        // last_of_run
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: copies of both matrices and the row count
    logic signed [15:0] mat_a [DIM*DIM];
    logic signed [15:0] mat_b [DIM*DIM];
    logic [2:0]         rows_reg = ROWS_RESET;
    t_c_entry           c_expect_q[$];

    // Stimulus bookkeeping
    t_elem_item         pending_q[$];
    t_elem_item         cur_item;
    bit [DIM*DIM-1:0]   a_set = '0;
    bit [DIM*DIM-1:0]   b_set = '0;
    int                 gen_rows = ROWS_RESET;
    int                 n_issued = 0;
    int                 n_accepted = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    t_stall_mode        stall_mode = STALL_NONE;
    int                 stall_cycle = 0;
    int                 cycle_count = 0;
    int                 err_count = 0;

    square_matrix_multiply #(.DIM(DIM)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Store a loaded element, or expand a compute transaction into product entries
    task automatic absorb_item(t_elem_item it);
        int                 rows;
        int                 n;
        logic signed [31:0] prod;
        logic signed [33:0] acc;
        t_c_entry           ent;
        case (it.op)
            OP_LOAD_A: mat_a[it.row * DIM + it.col] = it.value;
            OP_LOAD_B: mat_b[it.row * DIM + it.col] = it.value;
            OP_COMPUTE: begin
                rows = (rows_reg > DIM) ? DIM : rows_reg;
                n = 0;
                for (int i = 0; i < rows; i++) begin
                    for (int k = 0; k < DIM; k++) begin
                        acc = '0;
                        for (int j = 0; j < DIM; j++) begin
                            prod = mat_a[i * DIM + j] * mat_b[j * DIM + k];
                            acc = acc + prod;
                        end
                        n++;
                        ent.row  = 2'(i);
                        ent.col  = 2'(k);
                        ent.sum  = acc;
                        ent.last = (n == rows * DIM);
                        c_expect_q.push_back(ent);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Compare one output transaction with the oldest expected product
    task automatic check_product();
        t_c_entry ent;
        if (c_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected product row %0d col %0d",
                                      m_axis_tdata[1:0], m_axis_tdata[3:2]));
            return;
        end
        ent = c_expect_q.pop_front();
        if (m_axis_tdata[1:0] !== ent.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", m_axis_tdata[1:0], ent.row));
        if (m_axis_tdata[3:2] !== ent.col)
            report_mismatch($sformatf("out_col %0d, expected %0d", m_axis_tdata[3:2], ent.col));
        if ($signed(m_axis_tdata[37:4]) !== ent.sum)
            report_mismatch($sformatf("product [%0d][%0d] = %0d, expected %0d", ent.row,
                                      ent.col, $signed(m_axis_tdata[37:4]), ent.sum));
        if (m_axis_tlast !== ent.last)
            report_mismatch($sformatf("tlast %b on [%0d][%0d], expected %b", m_axis_tlast,
                                      ent.row, ent.col, ent.last));
    endtask

    // Driver: present pending items in bursts separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_item(cur_item);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    s_axis_tdata  <= {4'b0, cur_item.value, cur_item.col, cur_item.row};
                    s_axis_tuser  <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each product transaction, stall on a mode that is re-picked at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_product();
            stall_cycle++;
            if (stall_cycle % 80 == 0)
                stall_mode = t_stall_mode'($urandom_range(0, 2));
            case (stall_mode)
                STALL_NONE:    m_axis_tready <= 1'b1;
                STALL_RANDOM:  m_axis_tready <= ($urandom_range(0, 9) < 7);
                default:       m_axis_tready <= ((stall_cycle % 5) >= 2);
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** square_matrix_multiply: FAILED **");
            $finish;
        end
    end

    // Write rows_in_use, then read it back
    task automatic set_rows(int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROWS_IN_USE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rows_reg = 3'(value);
        gen_rows = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {29'd0, rows_reg})
            report_mismatch($sformatf("rows_in_use reads %0d, expected %0d", prdata, rows_reg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_item(t_op op, int row, int col, logic signed [15:0] value);
        t_elem_item it;
        it.op    = op;
        it.row   = 2'(row);
        it.col   = 2'(col);
        it.value = value;
        if (op == OP_LOAD_A)
            a_set[row * DIM + col] = 1'b1;
        if (op == OP_LOAD_B)
            b_set[row * DIM + col] = 1'b1;
        pending_q.push_back(it);
        n_issued++;
    endtask

    function automatic logic signed [15:0] pick_value();
        logic signed [15:0] corners [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    // Index of an entry that a compute at the current row count would read unwritten:
    // A entries first, then B entries offset by DIM*DIM; -1 when all are written
    function automatic int missing_entry();
        int rows;
        rows = (gen_rows > DIM) ? DIM : gen_rows;
        for (int e = 0; e < rows * DIM; e++)
            if (!a_set[e])
                return e;
        for (int e = 0; e < DIM * DIM; e++)
            if (!b_set[e])
                return DIM * DIM + e;
        return -1;
    endfunction

    task automatic queue_random_item(bit want_compute);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (want_compute || pick < 12) begin
            idx = missing_entry();
            if (idx < 0)
                queue_item(OP_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
            else if (idx < DIM * DIM)
                queue_item(OP_LOAD_A, idx / DIM, idx % DIM, pick_value());
            else
                queue_item(OP_LOAD_B, (idx - DIM * DIM) / DIM, idx % DIM, pick_value());
        end else if (pick < 57) begin
            // Prefer filling A entries that are still unwritten
            idx = -1;
            if (a_set != '1 && $urandom_range(0, 9) < 7)
                for (int e = DIM * DIM - 1; e >= 0; e--)
                    if (!a_set[e])
                        idx = e;
            if (idx < 0)
                idx = $urandom_range(0, DIM * DIM - 1);
            queue_item(OP_LOAD_A, idx / DIM, idx % DIM, pick_value());
        end else if (pick < 92) begin
            queue_item(OP_LOAD_B, $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
        end else begin
            queue_item(OP_NONE, $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
        end
    endtask

    // Hold until every queued item is accepted and every product has arrived
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (n_accepted != n_issued || c_expect_q.size() != 0);
    endtask

    initial begin
        int phase_rows [8] = '{2, 0, 4, 7, 3, 5, 1, 6};
        logic signed [15:0] b_rows [4];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme operands for a one-row product, an unused opcode, then two computes
        set_rows(1);
        queue_item(OP_LOAD_A, 0, 0, 16'sh7FFF);
        queue_item(OP_LOAD_A, 0, 1, 16'sh8000);
        queue_item(OP_LOAD_A, 0, 2, 16'sh0000);
        queue_item(OP_LOAD_A, 0, 3, 16'shFFFF);
        b_rows = '{16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                queue_item(OP_LOAD_B, r, c, (c == 3 && r >= 2) ? pick_value() : b_rows[r]);
        queue_item(OP_NONE, 3, 3, 16'shFFFF);
        queue_item(OP_COMPUTE, 0, 0, 16'sh0000);
        queue_item(OP_COMPUTE, 3, 3, 16'sh7FFF);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Random: one phase per row count, each closed by a compute, or by a load of an entry it would read unwritten
        foreach (phase_rows[p]) begin
            set_rows(phase_rows[p]);
            repeat (PHASE_ITEMS - 1) queue_random_item(1'b0);
            queue_random_item(1'b1);
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        if (c_expect_q.size() != 0)
            report_mismatch($sformatf("%0d products never arrived", c_expect_q.size()));
        if (err_count == 0) begin
            $display("** square_matrix_multiply: PASSED **");
        end else begin
            $display("** square_matrix_multiply: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/smm_pkg.sv
hdl/square_matrix_multiply.sv
test/tb.sv
